### rtl/core/tdc_pkg.sv
`default_nettype none
package tdc_pkg;

   // field widths
   localparam int COORD_W = 16;
   localparam int COST_W  = 32;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 3;

   // distance path: differences, squares, sum, square root radicand
   localparam int DIFF_W = 18;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int ROOT_W = 31;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   localparam int FRAC_SHIFT = RAD_W - SUM_W;

   // overlap path: extents, areas, division
   localparam int EXT_W  = COORD_W + 3;
   localparam int SPAN_W = COORD_W + 1;
   localparam int AREA_W = 2 * COORD_W + 1;
   localparam int UNI_W  = AREA_W + 1;
   localparam int DIV_W  = UNI_W + 1;
   localparam int Q_W    = 17;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef enum logic [1:0] {
      MODE_CENTER = 2'd0,
      MODE_RECT   = 2'd1,
      MODE_IOU    = 2'd2,
      MODE_BAD    = 2'd3
   } cost_mode_type;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [IDX_W-1:0] CSR_PRED_X = 3'd1;
   localparam logic [IDX_W-1:0] CSR_PRED_Y = 3'd2;
   localparam logic [IDX_W-1:0] CSR_LAST_X = 3'd3;
   localparam logic [IDX_W-1:0] CSR_LAST_Y = 3'd4;
   localparam logic [IDX_W-1:0] CSR_LAST_W = 3'd5;
   localparam logic [IDX_W-1:0] CSR_LAST_H = 3'd6;

   typedef struct packed {
      logic valid;
      logic use_div;
      logic err;
   } tdc_tag_type;

   typedef struct packed {
      tdc_tag_type             tag;
      logic [ROOT_W-1:0]       root;
      logic [Q_W-1:0]          quot;
   } tdc_res_type;

endpackage
`default_nettype wire

### rtl/core/tdc_root_div.sv
`default_nettype none
module tdc_root_div import tdc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire tdc_tag_type       in_tag,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire logic [UNI_W-1:0]  in_num,
   input  wire logic [UNI_W-1:0]  in_den,
   output tdc_res_type            res
);

   // one root bit and (for the first Q_W stages) one quotient bit per stage
   tdc_tag_type        tag_ff  [0:ROOT_W];
   logic [RAD_W-1:0]   rad_ff  [0:ROOT_W];
   logic [REM_W-1:0]   rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]  root_ff [0:ROOT_W];
   logic [UNI_W-1:0]   r_ff    [0:ROOT_W];
   logic [UNI_W-1:0]   u_ff    [0:ROOT_W];
   logic [Q_W-1:0]     q_ff    [0:ROOT_W];

   // next values of every stage
   logic [REM_W-1:0]   rem_in  [0:ROOT_W-1];
   logic [ROOT_W-1:0]  root_in [0:ROOT_W-1];
   logic [UNI_W-1:0]   r_in    [0:ROOT_W-1];
   logic [Q_W-1:0]     q_in    [0:ROOT_W-1];

   always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      logic             r_ge;
      logic [DIV_W-1:0] dt;
      logic             d_ge;
      for (int j = 0; j < ROOT_W; j++) begin
         // square root step: bring down two radicand bits
         rem_t      = {rem_ff[j][REM_W-3:0], rad_ff[j][RAD_W-1 -: 2]};
         trial      = {1'b0, root_ff[j], 2'b01};
         r_ge       = rem_t >= trial;
         rem_in[j]  = r_ge ? rem_t - trial : rem_t;
         root_in[j] = {root_ff[j][ROOT_W-2:0], r_ge};

         // division step: integer bit first, then fraction bits
         if (j < Q_W) begin
            if (j == 0) dt = {1'b0, r_ff[j]};
            else dt = {r_ff[j], 1'b0};
            d_ge    = dt >= {1'b0, u_ff[j]};
            r_in[j] = d_ge ? UNI_W'(dt - {1'b0, u_ff[j]}) : UNI_W'(dt);
            q_in[j] = {q_ff[j][Q_W-2:0], d_ge};
         end else begin
            r_in[j] = r_ff[j];
            q_in[j] = q_ff[j];
         end
      end
   end

   // stage entry and stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= ROOT_W; j++) begin
            tag_ff[j] <= '0;
         end
      end else if (adv) begin
         tag_ff[0] <= in_tag;
         for (int j = 0; j < ROOT_W; j++) begin
            tag_ff[j+1] <= tag_ff[j];
         end
      end
      if (adv) begin
         rad_ff[0]  <= in_rad;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         r_ff[0]    <= in_num;
         u_ff[0]    <= in_den;
         q_ff[0]    <= '0;
         for (int j = 0; j < ROOT_W; j++) begin
            rad_ff[j+1]  <= {rad_ff[j][RAD_W-3:0], 2'b00};
            rem_ff[j+1]  <= rem_in[j];
            root_ff[j+1] <= root_in[j];
            r_ff[j+1]    <= r_in[j];
            u_ff[j+1]    <= u_ff[j];
            q_ff[j+1]    <= q_in[j];
         end
      end
   end

   assign res.tag  = tag_ff[ROOT_W];
   assign res.root = root_ff[ROOT_W];
   assign res.quot = q_ff[ROOT_W];

endmodule
`default_nettype wire

### rtl/core/track_detection_cost_unit.sv
`default_nettype none
// Scores one candidate box against the track held in the csr registers and
// returns one word with a cost (Q20.12 for distances, Q16.16 for IoU) and an
// error flag per candidate. A new candidate is taken every cycle unless the
// result side stalls; a word passes through three front stages (differences
// and overlaps, multipliers, sums), an entry register and 31 stages of a
// bit-per-stage square root that also carries the 17-step IoU divider, and
// the output register. Any stall on the result side holds the whole
// pipeline. Registers may be written only while no candidate is in flight.
module track_detection_cost_unit import tdc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [IDX_W-1:0]    csr_index,
   input  wire logic [CSR_W-1:0]    csr_wdata,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic signed [COORD_W-1:0] req_cand_x,
   input  wire logic signed [COORD_W-1:0] req_cand_y,
   input  wire logic [COORD_W-1:0]  req_cand_w,
   input  wire logic [COORD_W-1:0]  req_cand_h,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [COST_W-1:0]   rsp_cost,
   output      logic                rsp_cost_error
);

   cost_mode_type              mode_ff;
   logic signed [COORD_W-1:0]  pred_x_ff, pred_y_ff, last_x_ff, last_y_ff;
   logic [COORD_W-1:0]         last_w_ff, last_h_ff;
   logic                       adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_CENTER;
         pred_x_ff <= '0;
         pred_y_ff <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         last_w_ff <= '0;
         last_h_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MODE:   mode_ff   <= cost_mode_type'(csr_wdata[1:0]);
            CSR_PRED_X: pred_x_ff <= csr_wdata;
            CSR_PRED_Y: pred_y_ff <= csr_wdata;
            CSR_LAST_X: last_x_ff <= csr_wdata;
            CSR_LAST_Y: last_y_ff <= csr_wdata;
            CSR_LAST_W: last_w_ff <= csr_wdata;
            CSR_LAST_H: last_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the output register is free
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---- stage 1: differences and overlap spans
   logic signed [DIFF_W-1:0] hw, hh, d0_in, d1_in, d2_in, d3_in;
   logic signed [EXT_W-1:0]  cx, cy, lx, ly, lo_x, lo_y, ae_x, ae_y, be_x, be_y;
   logic signed [EXT_W-1:0]  hi_x, hi_y, iw_in, ih_in;
   logic                     rect;

   always_comb begin
      rect  = mode_ff == MODE_RECT;
      hw    = rect ? DIFF_W'({last_w_ff[COORD_W-1:5], 4'b0}) : '0;
      hh    = rect ? DIFF_W'({last_h_ff[COORD_W-1:5], 4'b0}) : '0;
      d0_in = DIFF_W'(pred_x_ff) - hw - DIFF_W'(req_cand_x);
      d1_in = DIFF_W'(pred_y_ff) - hh - DIFF_W'(req_cand_y);
      d2_in = rect ? $signed({2'b0, last_w_ff}) - $signed({2'b0, req_cand_w}) : '0;
      d3_in = rect ? $signed({2'b0, last_h_ff}) - $signed({2'b0, req_cand_h}) : '0;
      cx    = EXT_W'(req_cand_x);
      cy    = EXT_W'(req_cand_y);
      lx    = EXT_W'(last_x_ff);
      ly    = EXT_W'(last_y_ff);
      lo_x  = (cx > lx) ? cx : lx;
      lo_y  = (cy > ly) ? cy : ly;
      ae_x  = cx + $signed({3'b0, req_cand_w});
      ae_y  = cy + $signed({3'b0, req_cand_h});
      be_x  = lx + $signed({3'b0, last_w_ff});
      be_y  = ly + $signed({3'b0, last_h_ff});
      hi_x  = (ae_x < be_x) ? ae_x : be_x;
      hi_y  = (ae_y < be_y) ? ae_y : be_y;
      iw_in = hi_x - lo_x;
      ih_in = hi_y - lo_y;
   end

   logic                     s1_valid_ff;
   cost_mode_type            s1_mode_ff;
   logic signed [DIFF_W-1:0] s1_d_ff [0:3];
   logic signed [EXT_W-1:0]  s1_iw_ff, s1_ih_ff;
   logic [COORD_W-1:0]       s1_cw_ff, s1_ch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
      if (adv) begin
         s1_mode_ff <= mode_ff;
         s1_d_ff[0] <= d0_in;
         s1_d_ff[1] <= d1_in;
         s1_d_ff[2] <= d2_in;
         s1_d_ff[3] <= d3_in;
         s1_iw_ff   <= iw_in;
         s1_ih_ff   <= ih_in;
         s1_cw_ff   <= req_cand_w;
         s1_ch_ff   <= req_cand_h;
      end
   end

   // ---- stage 2: squares and areas
   logic                s2_valid_ff;
   cost_mode_type       s2_mode_ff;
   logic [SQ_W-1:0]     s2_sq_ff [0:3];
   logic [AREA_W-1:0]   s2_ac_ff, s2_al_ff, s2_ai_ff;
   logic                overlap_in;

   assign overlap_in = (s1_iw_ff > 0) && (s1_ih_ff > 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_mode_ff <= s1_mode_ff;
         for (int k = 0; k < 4; k++) begin
            s2_sq_ff[k] <= SQ_W'(s1_d_ff[k] * s1_d_ff[k]);
         end
         s2_ac_ff <= AREA_W'(s1_cw_ff * s1_ch_ff);
         s2_al_ff <= AREA_W'(last_w_ff * last_h_ff);
         s2_ai_ff <= overlap_in ? AREA_W'(s1_iw_ff[SPAN_W-1:0] * s1_ih_ff[SPAN_W-1:0]) : '0;
      end
   end

   // ---- stage 3: sum of squares, union, error flag
   logic [SUM_W-1:0]  sum_in;
   logic [UNI_W-1:0]  uni_in, num_in;
   logic              err_in;
   tdc_tag_type       s3_tag_ff;
   logic [RAD_W-1:0]  s3_rad_ff;
   logic [UNI_W-1:0]  s3_num_ff, s3_den_ff;

   always_comb begin
      sum_in = SUM_W'(s2_sq_ff[0]) + SUM_W'(s2_sq_ff[1])
             + SUM_W'(s2_sq_ff[2]) + SUM_W'(s2_sq_ff[3]);
      uni_in = UNI_W'(s2_ac_ff) + UNI_W'(s2_al_ff) - UNI_W'(s2_ai_ff);
      num_in = uni_in - UNI_W'(s2_ai_ff);
      err_in = (s2_mode_ff == MODE_BAD) || (s2_mode_ff == MODE_IOU && uni_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff <= '0;
      end else if (adv) begin
         s3_tag_ff.valid   <= s2_valid_ff;
         s3_tag_ff.use_div <= s2_mode_ff == MODE_IOU;
         s3_tag_ff.err     <= err_in;
      end
      if (adv) begin
         s3_rad_ff <= {sum_in, FRAC_SHIFT'(0)};
         s3_num_ff <= num_in;
         s3_den_ff <= uni_in;
      end
   end

   // ---- root and divider pipeline
   tdc_res_type res;

   tdc_root_div u_root_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_tag  (s3_tag_ff),
      .in_rad  (s3_rad_ff),
      .in_num  (s3_num_ff),
      .in_den  (s3_den_ff),
      .res     (res)
   );

   // ---- output register
   logic               rsp_valid_ff;
   logic [COST_W-1:0]  rsp_cost_ff;
   logic               rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res.tag.valid;
      end
      if (adv) begin
         rsp_err_ff <= res.tag.err;
         if (res.tag.err) rsp_cost_ff <= COST_MAX;
         else if (res.tag.use_div) rsp_cost_ff <= COST_W'(res.quot);
         else rsp_cost_ff <= COST_W'(res.root);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cost       = rsp_cost_ff;
   assign rsp_cost_error = rsp_err_ff;

endmodule
`default_nettype wire
